@@ sv/wshc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wshc_pkg: shared types and constants of the window size-hint constrainer
// Field widths, internal datapath widths, register map and the sideband
// structs that travel between the top level and the snap pipeline.
// ---------------------------------------------------------------------------
package wshc_pkg;

	localparam int DIM_W     = 16;  // one coordinate or size field
	localparam int BW_W      = 8;   // border width
	localparam int POS_W     = 20;  // edge arithmetic, signed
	localparam int SZ_W      = 18;  // size after base removal, signed
	localparam int PROD_W    = 35;  // Q8.8 aspect product, signed
	localparam int VAL_W     = 26;  // size after aspect, signed
	localparam int MAG_W     = 24;  // magnitude into the remainder pipe
	localparam int REM_STEPS = 3;   // remainder bits resolved per stage

	localparam int NUM_LANES   = 2;
	localparam int LANE_WIDTH  = 0;
	localparam int LANE_HEIGHT = 1;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SIZE_BASE = 3'd0,
		REG_SIZE_MIN  = 3'd1,
		REG_SIZE_MAX  = 3'd2,
		REG_SIZE_INC  = 3'd3,
		REG_ASPECT    = 3'd4,
		REG_SCREEN    = 3'd5,
		REG_AREA_ORG  = 3'd6,
		REG_AREA_SIZE = 3'd7
	} wshc_reg_t;

	// Per-item data that rides along the snap pipeline untouched
	typedef struct packed {
		logic signed [DIM_W-1:0] x;
		logic signed [DIM_W-1:0] y;
		logic signed [DIM_W-1:0] cur_x;
		logic signed [DIM_W-1:0] cur_y;
		logic        [DIM_W-1:0] cur_w;
		logic        [DIM_W-1:0] cur_h;
		logic                    hint_on;
	} wshc_side_t;

	// One size lane: sign, snap enable and magnitude
	typedef struct packed {
		logic             neg;
		logic             en;
		logic [MAG_W-1:0] mag;
	} wshc_lane_t;

endpackage

@@ sv/window_size_hint_constrain_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// window_size_hint_constrain_unit: window geometry constrainer
// Clamps a requested window rectangle to the screen or work area, raises it
// to a minimum size and applies base, aspect, increment and min/max hints.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ----------------------------
// request   in         start & !busy             req_x/y/w/h, interactive,
//                                                apply_hints, cur_x/y/w/h,
//                                                border_width
// result    out        done, one-cycle strobe    new_x/y/w/h, changed
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Fully pipelined: one item per clock, no stall source inside. busy stays
// low, so start alone takes an item every cycle.
// Pipeline: 5 front stages (edge clamp, minimum size, aspect multiply, aspect
// select, sign split), 8 stages of increment remainder (3 bits each over a
// 24-bit magnitude) and 3 back stages (base restore, minimum, maximum and
// saturation into the output register). The receiver cannot stall, so
// results are never held; done pulses once per item, in request order.
// Reset clears the valid chain and all hint registers to zero; config is
// only to be written by the user while nothing is in flight, and the block
// itself does not enforce this.
// ---------------------------------------------------------------------------
module window_size_hint_constrain_unit import wshc_pkg::*; #(
	parameter int MIN_SIZE = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request
	input  logic                    start,
	output logic                    busy,
	input  logic signed [DIM_W-1:0] req_x,
	input  logic signed [DIM_W-1:0] req_y,
	input  logic signed [DIM_W-1:0] req_w,
	input  logic signed [DIM_W-1:0] req_h,
	input  logic                    interactive,
	input  logic                    apply_hints,
	input  logic signed [DIM_W-1:0] cur_x,
	input  logic signed [DIM_W-1:0] cur_y,
	input  logic        [DIM_W-1:0] cur_w,
	input  logic        [DIM_W-1:0] cur_h,
	input  logic        [BW_W-1:0]  border_width,
	// result
	output logic                    done,
	output logic signed [DIM_W-1:0] new_x,
	output logic signed [DIM_W-1:0] new_y,
	output logic        [DIM_W-1:0] new_w,
	output logic        [DIM_W-1:0] new_h,
	output logic                    changed,
	// config
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam logic [DIM_W-1:0] MinSize = DIM_W'(MIN_SIZE);
	localparam logic signed [PROD_W-1:0] RndHalf = PROD_W'(128);
	localparam logic signed [PROD_W-1:0] RndNeg  = PROD_W'(383);
	localparam logic signed [VAL_W-1:0]  DimMax  = signed'(VAL_W'({DIM_W{1'b1}}));

	// Clamp a signed edge to the 16-bit signed range.
	function automatic logic signed [DIM_W-1:0] sat_edge(input logic signed [POS_W-1:0] v);
		logic signed [POS_W-1:0] lo;
		logic signed [POS_W-1:0] hi;
		lo = POS_W'(signed'({1'b1, {(DIM_W-1){1'b0}}}));
		hi = POS_W'(signed'({1'b0, {(DIM_W-1){1'b1}}}));
		if (v < lo) begin
			return lo[DIM_W-1:0];
		end else if (v > hi) begin
			return hi[DIM_W-1:0];
		end
		return v[DIM_W-1:0];
	endfunction

	// Q8.8 product back to an integer: add one half, truncate toward zero.
	function automatic logic signed [VAL_W-1:0] round_q8(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		s = p + ((p < -RndHalf) ? RndNeg : RndHalf);
		return VAL_W'(s >>> 8);
	endfunction

	// Apply an optional maximum and saturate at the unsigned field maximum.
	function automatic logic [DIM_W-1:0] cap_size(input logic signed [VAL_W-1:0] v,
	                                               input logic [DIM_W-1:0] lim);
		if (lim != '0 && v > signed'(VAL_W'(lim))) begin
			return lim;
		end else if (v > DimMax) begin
			return {DIM_W{1'b1}};
		end
		return v[DIM_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] cfg_q [NUM_REGS];

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			cfg_q[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
		end
	end

	logic        [DIM_W-1:0] base_w, base_h, min_w, min_h, max_w, max_h;
	logic        [DIM_W-1:0] inc_w, inc_h, asp_min, asp_max;
	logic        [DIM_W-1:0] scr_w, scr_h, area_w, area_h;
	logic signed [DIM_W-1:0] area_x, area_y;
	logic                    base_is_min, aspect_set;

	assign base_w  = cfg_q[REG_SIZE_BASE][DIM_W-1:0];
	assign base_h  = cfg_q[REG_SIZE_BASE][CFG_W-1:DIM_W];
	assign min_w   = cfg_q[REG_SIZE_MIN][DIM_W-1:0];
	assign min_h   = cfg_q[REG_SIZE_MIN][CFG_W-1:DIM_W];
	assign max_w   = cfg_q[REG_SIZE_MAX][DIM_W-1:0];
	assign max_h   = cfg_q[REG_SIZE_MAX][CFG_W-1:DIM_W];
	assign inc_w   = cfg_q[REG_SIZE_INC][DIM_W-1:0];
	assign inc_h   = cfg_q[REG_SIZE_INC][CFG_W-1:DIM_W];
	assign asp_min = cfg_q[REG_ASPECT][DIM_W-1:0];
	assign asp_max = cfg_q[REG_ASPECT][CFG_W-1:DIM_W];
	assign scr_w   = cfg_q[REG_SCREEN][DIM_W-1:0];
	assign scr_h   = cfg_q[REG_SCREEN][CFG_W-1:DIM_W];
	assign area_x  = signed'(cfg_q[REG_AREA_ORG][DIM_W-1:0]);
	assign area_y  = signed'(cfg_q[REG_AREA_ORG][CFG_W-1:DIM_W]);
	assign area_w  = cfg_q[REG_AREA_SIZE][DIM_W-1:0];
	assign area_h  = cfg_q[REG_AREA_SIZE][CFG_W-1:DIM_W];

	// With the base equal to the minimum the base comes off after aspect
	assign base_is_min = (base_w == min_w) && (base_h == min_h);
	assign aspect_set  = (asp_min != '0) && (asp_max != '0);

	// Edge bounds, widened so the pull-back cannot wrap
	logic signed [POS_W-1:0] scr_wp, scr_hp, area_xp, area_yp, area_ex, area_ey;

	assign scr_wp  = signed'(POS_W'(scr_w));
	assign scr_hp  = signed'(POS_W'(scr_h));
	assign area_xp = POS_W'(area_x);
	assign area_yp = POS_W'(area_y);
	assign area_ex = area_xp + signed'(POS_W'(area_w));
	assign area_ey = area_yp + signed'(POS_W'(area_h));

	// ---------------------------------------------------------------
	// Valid chain
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s14, valid_s15;
	logic accept;

	assign accept = start && !busy;

	// ---------------------------------------------------------------
	// Stage 1: clip sizes to 1, pull far edges back
	// ---------------------------------------------------------------
	logic        [DIM_W-1:0] w_clip, h_clip;
	logic        [BW_W:0]    bw2;
	logic signed [POS_W-1:0] px, py, outer_w, outer_h, x1, y1;

	assign w_clip  = (req_w[DIM_W-1] || req_w == '0) ? DIM_W'(1) : unsigned'(req_w);
	assign h_clip  = (req_h[DIM_W-1] || req_h == '0) ? DIM_W'(1) : unsigned'(req_h);
	assign bw2     = {border_width, 1'b0};
	assign px      = POS_W'(req_x);
	assign py      = POS_W'(req_y);
	assign outer_w = signed'(POS_W'(cur_w)) + signed'(POS_W'(bw2));
	assign outer_h = signed'(POS_W'(cur_h)) + signed'(POS_W'(bw2));

	always_comb begin
		if (interactive) begin
			x1 = (px > scr_wp) ? scr_wp - outer_w : px;
			y1 = (py > scr_hp) ? scr_hp - outer_h : py;
		end else begin
			x1 = (px >= area_ex) ? area_ex - outer_w : px;
			y1 = (py >= area_ey) ? area_ey - outer_h : py;
		end
	end

	logic signed [POS_W-1:0] x_s1, y_s1;
	logic        [DIM_W-1:0] w_s1, h_s1;
	logic        [BW_W:0]    bw2_s1;
	logic                    inter_s1, hint_s1;
	logic signed [DIM_W-1:0] cx_s1, cy_s1;
	logic        [DIM_W-1:0] cw_s1, ch_s1;

	always_ff @(posedge clk) begin
		x_s1     <= x1;
		y_s1     <= y1;
		w_s1     <= w_clip;
		h_s1     <= h_clip;
		bw2_s1   <= bw2;
		inter_s1 <= interactive;
		hint_s1  <= apply_hints;
		cx_s1    <= cur_x;
		cy_s1    <= cur_y;
		cw_s1    <= cur_w;
		ch_s1    <= cur_h;
	end

	// ---------------------------------------------------------------
	// Stage 2: pull near edges forward, raise to the minimum size,
	// remove the base first when it differs from the minimum
	// ---------------------------------------------------------------
	logic signed [POS_W-1:0] ext_x, ext_y, x2, y2;
	logic        [DIM_W-1:0] w_min, h_min;
	logic signed [SZ_W-1:0]  w2, h2;
	logic                    pre_base;

	assign ext_x = x_s1 + signed'(POS_W'(w_s1)) + signed'(POS_W'(bw2_s1));
	assign ext_y = y_s1 + signed'(POS_W'(h_s1)) + signed'(POS_W'(bw2_s1));

	always_comb begin
		if (inter_s1) begin
			x2 = (ext_x < 0) ? '0 : x_s1;
			y2 = (ext_y < 0) ? '0 : y_s1;
		end else begin
			x2 = (ext_x <= area_xp) ? area_xp : x_s1;
			y2 = (ext_y <= area_yp) ? area_yp : y_s1;
		end
	end

	assign w_min    = (w_s1 < MinSize) ? MinSize : w_s1;
	assign h_min    = (h_s1 < MinSize) ? MinSize : h_s1;
	assign pre_base = hint_s1 && !base_is_min;
	assign w2 = signed'(SZ_W'(w_min)) - (pre_base ? signed'(SZ_W'(base_w)) : '0);
	assign h2 = signed'(SZ_W'(h_min)) - (pre_base ? signed'(SZ_W'(base_h)) : '0);

	logic signed [POS_W-1:0] x_s2, y_s2;
	logic signed [SZ_W-1:0]  w_s2, h_s2;
	logic                    hint_s2;
	logic signed [DIM_W-1:0] cx_s2, cy_s2;
	logic        [DIM_W-1:0] cw_s2, ch_s2;

	always_ff @(posedge clk) begin
		x_s2    <= x2;
		y_s2    <= y2;
		w_s2    <= w2;
		h_s2    <= h2;
		hint_s2 <= hint_s1;
		cx_s2   <= cx_s1;
		cy_s2   <= cy_s1;
		cw_s2   <= cw_s1;
		ch_s2   <= ch_s1;
	end

	// ---------------------------------------------------------------
	// Stage 3: aspect products, saturate the edges
	// ---------------------------------------------------------------
	logic signed [DIM_W:0]    asp_max_s, asp_min_s;
	logic signed [PROD_W-1:0] pw3, ph3;

	assign asp_max_s = signed'({1'b0, asp_max});
	assign asp_min_s = signed'({1'b0, asp_min});
	assign pw3 = asp_max_s * h_s2;   // max aspect times height
	assign ph3 = asp_min_s * w_s2;   // min aspect times width

	logic signed [PROD_W-1:0] pw_s3, ph_s3;
	logic signed [SZ_W-1:0]   w_s3, h_s3;
	logic signed [DIM_W-1:0]  x_s3, y_s3;
	logic                     hint_s3;
	logic signed [DIM_W-1:0]  cx_s3, cy_s3;
	logic        [DIM_W-1:0]  cw_s3, ch_s3;

	always_ff @(posedge clk) begin
		pw_s3   <= pw3;
		ph_s3   <= ph3;
		w_s3    <= w_s2;
		h_s3    <= h_s2;
		x_s3    <= sat_edge(x_s2);
		y_s3    <= sat_edge(y_s2);
		hint_s3 <= hint_s2;
		cx_s3   <= cx_s2;
		cy_s3   <= cy_s2;
		cw_s3   <= cw_s2;
		ch_s3   <= ch_s2;
	end

	// ---------------------------------------------------------------
	// Stage 4: exact ratio compare, pick the aspect-corrected side
	// ---------------------------------------------------------------
	logic signed [PROD_W-1:0] w256, h256;
	logic                     too_wide, too_tall, asp_on;
	logic signed [VAL_W-1:0]  w4, h4;

	assign w256   = PROD_W'(w_s3) <<< 8;
	assign h256   = PROD_W'(h_s3) <<< 8;
	assign asp_on = hint_s3 && aspect_set;

	always_comb begin
		// width/height above the max aspect; a zero height is infinite
		if (h_s3 > 0) begin
			too_wide = pw_s3 < w256;
		end else if (h_s3 < 0) begin
			too_wide = pw_s3 > w256;
		end else begin
			too_wide = w_s3 > 0;
		end
		// height/width above the min aspect
		if (w_s3 > 0) begin
			too_tall = ph_s3 < h256;
		end else if (w_s3 < 0) begin
			too_tall = ph_s3 > h256;
		end else begin
			too_tall = h_s3 > 0;
		end
	end

	assign w4 = (asp_on && too_wide) ? round_q8(pw_s3) : VAL_W'(w_s3);
	assign h4 = (asp_on && !too_wide && too_tall) ? round_q8(ph_s3) : VAL_W'(h_s3);

	logic signed [VAL_W-1:0] w_s4, h_s4;
	logic signed [DIM_W-1:0] x_s4, y_s4;
	logic                    hint_s4;
	logic signed [DIM_W-1:0] cx_s4, cy_s4;
	logic        [DIM_W-1:0] cw_s4, ch_s4;

	always_ff @(posedge clk) begin
		w_s4    <= w4;
		h_s4    <= h4;
		x_s4    <= x_s3;
		y_s4    <= y_s3;
		hint_s4 <= hint_s3;
		cx_s4   <= cx_s3;
		cy_s4   <= cy_s3;
		cw_s4   <= cw_s3;
		ch_s4   <= ch_s3;
	end

	// ---------------------------------------------------------------
	// Stage 5: late base removal, split into sign and magnitude
	// ---------------------------------------------------------------
	logic                       post_base;
	logic signed [VAL_W-1:0]    w5, h5;
	wshc_lane_t [NUM_LANES-1:0] lane5;
	wshc_side_t                 side5;

	assign post_base = hint_s4 && base_is_min;
	assign w5 = w_s4 - (post_base ? signed'(VAL_W'(base_w)) : '0);
	assign h5 = h_s4 - (post_base ? signed'(VAL_W'(base_h)) : '0);

	always_comb begin
		lane5[LANE_WIDTH].neg  = w5[VAL_W-1];
		lane5[LANE_WIDTH].en   = hint_s4 && (inc_w != '0);
		lane5[LANE_WIDTH].mag  = MAG_W'(w5[VAL_W-1] ? -w5 : w5);
		lane5[LANE_HEIGHT].neg = h5[VAL_W-1];
		lane5[LANE_HEIGHT].en  = hint_s4 && (inc_h != '0);
		lane5[LANE_HEIGHT].mag = MAG_W'(h5[VAL_W-1] ? -h5 : h5);
		side5.x       = x_s4;
		side5.y       = y_s4;
		side5.cur_x   = cx_s4;
		side5.cur_y   = cy_s4;
		side5.cur_w   = cw_s4;
		side5.cur_h   = ch_s4;
		side5.hint_on = hint_s4;
	end

	wshc_lane_t [NUM_LANES-1:0] lane_s5;
	wshc_side_t                 side_s5;

	always_ff @(posedge clk) begin
		lane_s5 <= lane5;
		side_s5 <= side5;
	end

	// ---------------------------------------------------------------
	// Stages 6..13: snap to increments (remainder follows the dividend)
	// ---------------------------------------------------------------
	logic                                snap_valid;
	wshc_side_t                          snap_side;
	wshc_lane_t [NUM_LANES-1:0]          snap_lane;
	logic       [NUM_LANES-1:0][DIM_W-1:0] incs;

	assign incs[LANE_WIDTH]  = inc_w;
	assign incs[LANE_HEIGHT] = inc_h;

	wshc_snap u_snap (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s5),
		.item_side  (side_s5),
		.item_lane  (lane_s5),
		.divisor    (incs),
		.snap_valid (snap_valid),
		.snap_side  (snap_side),
		.snap_lane  (snap_lane)
	);

	// ---------------------------------------------------------------
	// Stage 14: restore sign and add the base back
	// ---------------------------------------------------------------
	logic signed [VAL_W-1:0] bw_add, bh_add, mw, mh, w14, h14;

	assign bw_add = snap_side.hint_on ? signed'(VAL_W'(base_w)) : '0;
	assign bh_add = snap_side.hint_on ? signed'(VAL_W'(base_h)) : '0;
	assign mw     = signed'(VAL_W'(snap_lane[LANE_WIDTH].mag));
	assign mh     = signed'(VAL_W'(snap_lane[LANE_HEIGHT].mag));
	assign w14    = snap_lane[LANE_WIDTH].neg  ? bw_add - mw : bw_add + mw;
	assign h14    = snap_lane[LANE_HEIGHT].neg ? bh_add - mh : bh_add + mh;

	logic signed [VAL_W-1:0] w_s14, h_s14;
	wshc_side_t              side_s14;

	always_ff @(posedge clk) begin
		w_s14    <= w14;
		h_s14    <= h14;
		side_s14 <= snap_side;
	end

	// ---------------------------------------------------------------
	// Stage 15: raise to the minimum hint
	// ---------------------------------------------------------------
	logic signed [VAL_W-1:0] lo_w, lo_h, w15, h15;

	assign lo_w = side_s14.hint_on ? signed'(VAL_W'(min_w)) : '0;
	assign lo_h = side_s14.hint_on ? signed'(VAL_W'(min_h)) : '0;
	assign w15  = (w_s14 < lo_w) ? lo_w : w_s14;
	assign h15  = (h_s14 < lo_h) ? lo_h : h_s14;

	logic signed [VAL_W-1:0] w_s15, h_s15;
	wshc_side_t              side_s15;

	always_ff @(posedge clk) begin
		w_s15    <= w15;
		h_s15    <= h15;
		side_s15 <= side_s14;
	end

	// ---------------------------------------------------------------
	// Output: maximum hint, saturate, compare with current rectangle
	// ---------------------------------------------------------------
	logic [DIM_W-1:0] w_fin, h_fin;

	assign w_fin = cap_size(w_s15, side_s15.hint_on ? max_w : '0);
	assign h_fin = cap_size(h_s15, side_s15.hint_on ? max_h : '0);

	always_ff @(posedge clk) begin
		new_x   <= side_s15.x;
		new_y   <= side_s15.y;
		new_w   <= w_fin;
		new_h   <= h_fin;
		changed <= (side_s15.x != side_s15.cur_x) || (side_s15.y != side_s15.cur_y) ||
		           (w_fin != side_s15.cur_w) || (h_fin != side_s15.cur_h);
	end

	// Advance valid bits with their items; the snap unit keeps its own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s14 <= 1'b0;
			valid_s15 <= 1'b0;
			done      <= 1'b0;
		end else begin
			valid_s1  <= accept;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s14 <= snap_valid;
			valid_s15 <= valid_s14;
			done      <= valid_s15;
		end
	end

endmodule

@@ sv/wshc_snap.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wshc_snap: pipelined increment snap for width and height
// Restoring remainder, REM_STEPS dividend bits per stage, both lanes side by
// side; the last stage takes the remainder off the magnitude.
// ---------------------------------------------------------------------------
module wshc_snap import wshc_pkg::*; (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  wshc_side_t                          item_side,
	input  wshc_lane_t [NUM_LANES-1:0]          item_lane,
	input  logic       [NUM_LANES-1:0][DIM_W-1:0] divisor,
	output logic                                snap_valid,
	output wshc_side_t                          snap_side,
	output wshc_lane_t [NUM_LANES-1:0]          snap_lane
);

	localparam int NumStages = MAG_W / REM_STEPS;

	logic                                 valid_s [NumStages];
	wshc_side_t                           side_s  [NumStages];
	wshc_lane_t [NUM_LANES-1:0]           lane_s  [NumStages];
	logic       [NUM_LANES-1:0][DIM_W-1:0] rem_s  [NumStages];

	for (genvar k = 0; k < NumStages; k++) begin : g_stage
		logic                                 st_valid;
		wshc_side_t                           st_side;
		wshc_lane_t [NUM_LANES-1:0]           st_lane;
		wshc_lane_t [NUM_LANES-1:0]           nx_lane;
		logic       [NUM_LANES-1:0][DIM_W-1:0] st_rem;
		logic       [NUM_LANES-1:0][DIM_W-1:0] nx_rem;

		if (k == 0) begin : g_head
			assign st_valid = item_valid;
			assign st_side  = item_side;
			assign st_lane  = item_lane;
			assign st_rem   = '0;
		end else begin : g_body
			assign st_valid = valid_s[k-1];
			assign st_side  = side_s[k-1];
			assign st_lane  = lane_s[k-1];
			assign st_rem   = rem_s[k-1];
		end

		always_comb begin
			logic [DIM_W-1:0] r;
			logic [DIM_W:0]   t;
			nx_lane = st_lane;
			nx_rem  = st_rem;
			for (int l = 0; l < NUM_LANES; l++) begin
				r = st_rem[l];
				for (int j = 0; j < REM_STEPS; j++) begin
					t = {r, st_lane[l].mag[MAG_W-1-k*REM_STEPS-j]};
					if (t >= {1'b0, divisor[l]}) begin
						r = DIM_W'(t - {1'b0, divisor[l]});
					end else begin
						r = t[DIM_W-1:0];
					end
				end
				nx_rem[l] = r;
				// drop the remainder once the last dividend bit is in
				if (k == NumStages - 1 && st_lane[l].en) begin
					nx_lane[l].mag = st_lane[l].mag - MAG_W'(r);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= st_valid;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= st_side;
			lane_s[k] <= nx_lane;
			rem_s[k]  <= nx_rem;
		end
	end

	assign snap_valid = valid_s[NumStages-1];
	assign snap_side  = side_s[NumStages-1];
	assign snap_lane  = lane_s[NumStages-1];

endmodule
